// ===== src/sjf_pkg.sv =====
// Shared types and constants for the shortest-job-first waiting-time engine.
// Used by the front end, back end and top level; depends on nothing else.
package sjf_pkg;

  localparam int BURST_W     = 16;
  localparam int POS_W       = 3;
  localparam int WAIT_W      = 19;
  localparam int AVG_W       = 27;
  localparam int FRAC_W      = 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_LW    = 3;

  typedef enum logic {
    OP_LOAD,
    OP_CLOSE
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [BURST_W-1:0] burst;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SUM,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_EMIT
  } back_state_t;

endpackage

// ===== src/sjf_front.sv =====
// Front end: takes command transactions, turns each into a load or close command
// and holds them in a short queue for the back end. Depends on sjf_pkg.
module sjf_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [sjf_pkg::BURST_W-1:0]  in_burst_time,
  input  logic                         in_last_job,
  input  logic                         pop,
  output logic                         empty,
  output sjf_pkg::cmd_t                cmd
);

  sjf_pkg::cmd_t                   q_r [sjf_pkg::QUEUE_DEPTH];
  logic [sjf_pkg::QUEUE_AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [sjf_pkg::QUEUE_AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [sjf_pkg::QUEUE_LW-1:0]    level_r, level_nxt;
  logic                            full;
  logic                            push;
  logic                            do_pop;
  sjf_pkg::cmd_t                   new_cmd;

  assign full   = (level_r == sjf_pkg::QUEUE_LW'(sjf_pkg::QUEUE_DEPTH));
  assign empty  = (level_r == '0);
  assign busy   = full;
  assign push   = start && !full;
  assign do_pop = pop && !empty;
  assign cmd    = q_r[rd_ptr_r];

  always_comb begin
    new_cmd.burst = in_burst_time;
    unique case (in_last_job)
      1'b1:    new_cmd.op = sjf_pkg::OP_CLOSE;
      default: new_cmd.op = sjf_pkg::OP_LOAD;
    endcase
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    level_nxt  = level_r;
    if (push && !do_pop) begin
      level_nxt = level_r + 1'b1;
    end else if (!push && do_pop) begin
      level_nxt = level_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule

// ===== src/sjf_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
// Used by the back end for the mean waiting time; depends on nothing else.
module sjf_div #(
  parameter int DIVD_W = 32,
  parameter int DIVS_W = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DIVS_W-1:0] divisor,
  output logic              done,
  output logic [DIVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVD_W + 1);

  logic              act_r, act_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DIVD_W-1:0] d_r, d_nxt;
  logic [DIVS_W-1:0] rem_r, rem_nxt;
  logic [DIVS_W:0]   rem_sh;
  logic [DIVS_W:0]   rem_sub;
  logic              ge;

  assign done     = done_r;
  assign quotient = d_r;

  always_comb begin
    rem_sh   = {rem_r, d_r[DIVD_W-1]};
    rem_sub  = rem_sh - {1'b0, divisor};
    ge       = (rem_sh >= {1'b0, divisor});
    act_nxt  = act_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    if (start) begin
      act_nxt = 1'b1;
      cnt_nxt = CNT_W'(DIVD_W);
      d_nxt   = dividend;
      rem_nxt = '0;
    end else if (act_r) begin
      d_nxt   = {d_r[DIVD_W-2:0], ge};
      rem_nxt = ge ? rem_sub[DIVS_W-1:0] : rem_sh[DIVS_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        act_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      act_r  <= act_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
  end

endmodule

// ===== src/sjf_back.sv =====
// Back end: keeps the set sorted by insertion as loads arrive, then sums the
// waiting times, has them divided and emits one result per job. Depends on sjf_pkg.
module sjf_back #(
  parameter int MAX_JOBS = 8,
  parameter int CW       = 4,
  parameter int DW       = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  input  sjf_pkg::cmd_t                q_cmd,
  output logic                         q_pop,
  output logic                         div_start,
  output logic [DW-1:0]                div_dividend,
  output logic [CW-1:0]                div_divisor,
  input  logic                         div_done,
  input  logic [DW-1:0]                div_quotient,
  output logic                         out_strobe,
  output logic [sjf_pkg::POS_W-1:0]    out_position,
  output logic [sjf_pkg::BURST_W-1:0]  out_sorted_burst,
  output logic [sjf_pkg::WAIT_W-1:0]   out_waiting_time,
  output logic [sjf_pkg::AVG_W-1:0]    out_average_wait,
  output logic                         out_last_result
);

  localparam int BURST_W = sjf_pkg::BURST_W;
  localparam int POS_W   = sjf_pkg::POS_W;
  localparam int WAIT_W  = sjf_pkg::WAIT_W;
  localparam int AVG_W   = sjf_pkg::AVG_W;
  localparam int FRAC_W  = sjf_pkg::FRAC_W;
  localparam int RUN_W   = BURST_W + CW;
  localparam int TOT_W   = DW - FRAC_W;

  sjf_pkg::back_state_t state_r, state_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [CW-1:0]        k_r, k_nxt;
  logic [RUN_W-1:0]     run_r, run_nxt;
  logic [TOT_W-1:0]     total_r, total_nxt;
  logic [DW-1:0]        avg_r, avg_nxt;
  logic [BURST_W-1:0]   row_r   [MAX_JOBS];
  logic [BURST_W-1:0]   row_nxt [MAX_JOBS];
  logic [BURST_W-1:0]   row_ins [MAX_JOBS];
  logic [BURST_W-1:0]   row_rot [MAX_JOBS];
  logic [MAX_JOBS-1:0]  gt;

  logic                 strobe_r, strobe_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [BURST_W-1:0]   burst_r, burst_nxt;
  logic [WAIT_W-1:0]    wait_r, wait_nxt;
  logic [AVG_W-1:0]     avgo_r, avgo_nxt;
  logic                 last_r, last_nxt;

  logic [CW+POS_W-1:0]    pos_ext;
  logic [RUN_W+WAIT_W-1:0] wait_ext;
  logic [DW+AVG_W-1:0]    avg_ext;
  logic                   room;
  logic                   final_k;

  assign out_strobe       = strobe_r;
  assign out_position     = pos_r;
  assign out_sorted_burst = burst_r;
  assign out_waiting_time = wait_r;
  assign out_average_wait = avgo_r;
  assign out_last_result  = last_r;

  assign div_dividend = {total_r, {FRAC_W{1'b0}}};
  assign div_divisor  = cnt_r;

  assign pos_ext  = {{POS_W{1'b0}}, k_r};
  assign wait_ext = {{WAIT_W{1'b0}}, run_r};
  assign avg_ext  = {{AVG_W{1'b0}}, avg_r};
  assign room     = (cnt_r < CW'(MAX_JOBS));
  assign final_k  = (k_r + 1'b1 == cnt_r);

  for (genvar g = 0; g < MAX_JOBS; g++) begin : g_cell
    assign gt[g] = (CW'(g) < cnt_r) && (row_r[g] > q_cmd.burst);
    if (g == 0) begin : g_head
      assign row_ins[g] = (gt[g] || cnt_r == '0) ? q_cmd.burst : row_r[g];
    end else begin : g_body
      assign row_ins[g] = gt[g-1] ? row_r[g-1] :
                          (gt[g] || CW'(g) == cnt_r) ? q_cmd.burst : row_r[g];
    end
    if (g == MAX_JOBS - 1) begin : g_tail
      assign row_rot[g] = (CW'(g) < cnt_r) ? row_r[0] : row_r[g];
    end else begin : g_mid
      assign row_rot[g] = (CW'(g + 1) == cnt_r) ? row_r[0] :
                          (CW'(g) < cnt_r) ? row_r[g + 1] : row_r[g];
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    k_nxt      = k_r;
    run_nxt    = run_r;
    total_nxt  = total_r;
    avg_nxt    = avg_r;
    row_nxt    = row_r;
    q_pop      = 1'b0;
    div_start  = 1'b0;
    strobe_nxt = 1'b0;
    pos_nxt    = pos_r;
    burst_nxt  = burst_r;
    wait_nxt   = wait_r;
    avgo_nxt   = avgo_r;
    last_nxt   = last_r;
    unique case (state_r)
      sjf_pkg::ST_LOAD: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (room) begin
            row_nxt = row_ins;
            cnt_nxt = cnt_r + 1'b1;
          end
          if (q_cmd.op == sjf_pkg::OP_CLOSE) begin
            state_nxt = sjf_pkg::ST_SUM;
            k_nxt     = '0;
            run_nxt   = '0;
            total_nxt = '0;
          end
        end
      end
      sjf_pkg::ST_SUM: begin
        row_nxt   = row_rot;
        total_nxt = total_r + TOT_W'(run_r);
        run_nxt   = run_r + RUN_W'(row_r[0]);
        k_nxt     = k_r + 1'b1;
        if (final_k) begin
          state_nxt = sjf_pkg::ST_DIV_GO;
        end
      end
      sjf_pkg::ST_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = sjf_pkg::ST_DIV_WAIT;
      end
      sjf_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          avg_nxt   = div_quotient;
          k_nxt     = '0;
          run_nxt   = '0;
          state_nxt = sjf_pkg::ST_EMIT;
        end
      end
      sjf_pkg::ST_EMIT: begin
        strobe_nxt = 1'b1;
        pos_nxt    = pos_ext[POS_W-1:0];
        burst_nxt  = row_r[0];
        wait_nxt   = wait_ext[WAIT_W-1:0];
        avgo_nxt   = avg_ext[AVG_W-1:0];
        last_nxt   = final_k;
        row_nxt    = row_rot;
        run_nxt    = run_r + RUN_W'(row_r[0]);
        k_nxt      = k_r + 1'b1;
        if (final_k) begin
          cnt_nxt   = '0;
          state_nxt = sjf_pkg::ST_LOAD;
        end
      end
      default: begin
        state_nxt = sjf_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= sjf_pkg::ST_LOAD;
      cnt_r    <= '0;
      k_r      <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      k_r      <= k_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    run_r   <= run_nxt;
    total_r <= total_nxt;
    avg_r   <= avg_nxt;
    row_r   <= row_nxt;
    pos_r   <= pos_nxt;
    burst_r <= burst_nxt;
    wait_r  <= wait_nxt;
    avgo_r  <= avgo_nxt;
    last_r  <= last_nxt;
  end

endmodule

// ===== src/sjf_waiting_time_engine_top.sv =====
// Top level of the shortest-job-first waiting-time engine: front end, back end
// and divider. Depends on sjf_pkg, sjf_front, sjf_back and sjf_div.
//
// Each transaction carries one job burst; a transaction with in_last_job set
// closes the set. Transactions go into a four-entry command queue, so busy
// rises only while that queue is full. The back end takes one queued job per
// cycle while it is loading and the queue is not empty, and keeps the set sorted
// as it goes. After it takes the closing job of a set it sums the waiting times,
// runs the bit-serial divider for the mean (DW = 16 + 2*clog2(MAX_JOBS+1) + 8,
// which is 32 for eight jobs), and then emits the results, one per
// cycle on consecutive cycles with out_strobe high. Results cannot be held off,
// so they must be taken in the cycle they appear. Jobs beyond MAX_JOBS in one
// set are dropped.
module sjf_waiting_time_engine_top #(
  parameter int MAX_JOBS = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [sjf_pkg::BURST_W-1:0]  in_burst_time,
  input  logic                         in_last_job,
  output logic                         out_strobe,
  output logic [sjf_pkg::POS_W-1:0]    out_position,
  output logic [sjf_pkg::BURST_W-1:0]  out_sorted_burst,
  output logic [sjf_pkg::WAIT_W-1:0]   out_waiting_time,
  output logic [sjf_pkg::AVG_W-1:0]    out_average_wait,
  output logic                         out_last_result
);

  localparam int CW     = $clog2(MAX_JOBS + 1);
  localparam int DW     = sjf_pkg::BURST_W + 2 * CW + sjf_pkg::FRAC_W;
  localparam int POS_W  = sjf_pkg::POS_W;
  localparam int WAIT_W = sjf_pkg::WAIT_W;

  logic          q_empty;
  logic          q_pop;
  sjf_pkg::cmd_t q_cmd;
  logic          div_start;
  logic          div_done;
  logic [DW-1:0] div_dividend;
  logic [DW-1:0] div_quotient;
  logic [CW-1:0] div_divisor;

  sjf_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_burst_time (in_burst_time),
    .in_last_job   (in_last_job),
    .pop           (q_pop),
    .empty         (q_empty),
    .cmd           (q_cmd)
  );

  sjf_back #(
    .MAX_JOBS (MAX_JOBS),
    .CW       (CW),
    .DW       (DW)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_cmd            (q_cmd),
    .q_pop            (q_pop),
    .div_start        (div_start),
    .div_dividend     (div_dividend),
    .div_divisor      (div_divisor),
    .div_done         (div_done),
    .div_quotient     (div_quotient),
    .out_strobe       (out_strobe),
    .out_position     (out_position),
    .out_sorted_burst (out_sorted_burst),
    .out_waiting_time (out_waiting_time),
    .out_average_wait (out_average_wait),
    .out_last_result  (out_last_result)
  );

  sjf_div #(
    .DIVD_W (DW),
    .DIVS_W (CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

`ifndef SYNTH
  a_set_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last_result |=> !out_strobe)
    else $error("A result followed the final result of a set.");

  a_rank_steps: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last_result |=>
      out_strobe && out_position == POS_W'($past(out_position) + 1'b1))
    else $error("Results of a set are not on consecutive ranks.");

  a_wait_grows: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last_result |=>
      out_waiting_time == WAIT_W'($past(out_waiting_time) + $past(out_sorted_burst)))
    else $error("Waiting time is not the sum of earlier bursts.");

  a_avg_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last_result |=> $stable(out_average_wait))
    else $error("Mean waiting time changed within a set.");
`endif

endmodule
